[rtl/assert_macros.svh]
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define SMD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// next-cycle implication, disabled while reset is high
`define SMD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

[rtl/sha256md_pkg.sv]
// types, constants and mixing functions for the sha-256 digest block
// no dependencies
package sha256md_pkg;

   typedef struct packed {
      logic [63:0] message_word;
      logic [3:0]  byte_count;
      logic        is_last;
   } req_data_type;

   typedef struct packed {
      logic [63:0] digest_part;
      logic [1:0]  part_index;
      logic        last_part;
   } rsp_data_type;

   // sequencer to round unit
   typedef struct packed {
      logic start;
      logic init_chain;
   } rnd_ctl_type;

   // round unit to sequencer
   typedef struct packed {
      logic done;
   } rnd_sts_type;

   localparam logic [31:0] INIT_HASH [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   function automatic logic [31:0] big_sigma0(input logic [31:0] x);
      big_sigma0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
   endfunction

   function automatic logic [31:0] big_sigma1(input logic [31:0] x);
      big_sigma1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
   endfunction

   function automatic logic [31:0] small_sigma0(input logic [31:0] x);
      small_sigma0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
   endfunction

   function automatic logic [31:0] small_sigma1(input logic [31:0] x);
      small_sigma1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
   endfunction

endpackage

[rtl/sha256md_round.sv]
// sha-256 compression unit: one round per cycle for 64 rounds, then the chain update
// depends on sha256md_pkg
module sha256md_round (
   input  logic                      clock,
   input  logic                      reset,
   input  sha256md_pkg::rnd_ctl_type ctl,
   input  logic [511:0]              block,
   output sha256md_pkg::rnd_sts_type sts,
   output logic [255:0]              chain
);

   logic [31:0] chain_ff [8];
   logic [31:0] chain_in [8];
   logic [31:0] var_ff [8];
   logic [31:0] var_in [8];
   logic [31:0] win_ff [16];
   logic [31:0] win_in [16];
   logic [5:0]  round_ff, round_in;
   logic        busy_ff, busy_in;
   logic        fin_ff, fin_in;

   logic [31:0] t1, t2, ch, maj, w_new;

   assign ch    = (var_ff[4] & var_ff[5]) ^ (~var_ff[4] & var_ff[6]);
   assign maj   = (var_ff[0] & var_ff[1]) ^ (var_ff[0] & var_ff[2]) ^ (var_ff[1] & var_ff[2]);
   assign t1    = var_ff[7] + sha256md_pkg::big_sigma1(var_ff[4]) + ch
                  + sha256md_pkg::ROUND_K[round_ff] + win_ff[0];
   assign t2    = sha256md_pkg::big_sigma0(var_ff[0]) + maj;
   // schedule word sixteen places ahead of the current one
   assign w_new = sha256md_pkg::small_sigma1(win_ff[14]) + win_ff[9]
                  + sha256md_pkg::small_sigma0(win_ff[1]) + win_ff[0];

   always_comb begin
      chain_in = chain_ff;
      var_in   = var_ff;
      win_in   = win_ff;
      round_in = round_ff;
      busy_in  = busy_ff;
      fin_in   = 1'b0;
      if (ctl.start) begin
         for (int i = 0; i < 8; i++) begin
            var_in[i] = chain_ff[i];
         end
         for (int i = 0; i < 16; i++) begin
            win_in[i] = block[511 - 32*i -: 32];
         end
         round_in = 6'd0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         var_in[7] = var_ff[6];
         var_in[6] = var_ff[5];
         var_in[5] = var_ff[4];
         var_in[4] = var_ff[3] + t1;
         var_in[3] = var_ff[2];
         var_in[2] = var_ff[1];
         var_in[1] = var_ff[0];
         var_in[0] = t1 + t2;
         for (int i = 0; i < 15; i++) begin
            win_in[i] = win_ff[i+1];
         end
         win_in[15] = w_new;
         round_in   = round_ff + 6'd1;
         if (round_ff == 6'd63) begin
            busy_in = 1'b0;
            fin_in  = 1'b1;
         end
      end
      if (fin_ff) begin
         for (int i = 0; i < 8; i++) begin
            chain_in[i] = chain_ff[i] + var_ff[i];
         end
      end
      if (ctl.init_chain) begin
         chain_in = sha256md_pkg::INIT_HASH;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff <= sha256md_pkg::INIT_HASH;
         round_ff <= 6'd0;
         busy_ff  <= 1'b0;
         fin_ff   <= 1'b0;
      end else begin
         chain_ff <= chain_in;
         round_ff <= round_in;
         busy_ff  <= busy_in;
         fin_ff   <= fin_in;
      end
   end

   always_ff @(posedge clock) begin
      var_ff <= var_in;
      win_ff <= win_in;
   end

   assign sts.done = fin_ff;

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         chain[255 - 32*i -: 32] = chain_ff[i];
      end
   end

endmodule

[rtl/sha256_message_digest.sv]
// sha-256 digest top level: byte packing sequencer, block shift register, padding
// depends on sha256md_pkg and sha256md_round
//
// usage
//   req channel: one item carries message_word with byte_count (0..8, larger
//   counts act as 8) leading bytes, first byte in bits 63..56; is_last marks the
//   final item of a message. req_ready is high only while the block is idle.
//   rsp channel: after the last item four items follow, part_index 0..3, each
//   holding two hash words (the lower-numbered word in bits 63..32); last_part
//   is set on part 3. the block then clears itself for the next message.
// timing
//   an item is taken in the idle state and packed into the 64-byte block register
//   in the load state, which is entered again after a compression when the item
//   reaches the end of a block. each full block runs through the round unit
//   (start, 64 rounds, chain add); no new item is taken before the previous one
//   is packed. the last item adds padding, the length field and one or two
//   compressions before the first digest part shows.
// reset and stalls
//   synchronous active-high reset loads the initial hash and empties the block.
//   while rsp_ready is low the current digest part holds and no item is taken.
module sha256_message_digest (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  sha256md_pkg::req_data_type req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output sha256md_pkg::rsp_data_type rsp_data
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_LOAD = 3'd1;
   localparam logic [2:0] S_MARK = 3'd2;
   localparam logic [2:0] S_ZERO = 3'd3;
   localparam logic [2:0] S_LEN  = 3'd4;
   localparam logic [2:0] S_KICK = 3'd5;
   localparam logic [2:0] S_WAIT = 3'd6;
   localparam logic [2:0] S_OUT  = 3'd7;

   localparam logic [63:0] PAD_WORD = 64'h8000_0000_0000_0000;

   logic [2:0]   state_ff, state_in;
   logic [2:0]   ret_ff, ret_in;
   logic [63:0]  pend_ff, pend_in;
   logic [3:0]   pend_cnt_ff, pend_cnt_in;
   logic         last_ff, last_in;
   logic [5:0]   fill_ff, fill_in;
   logic [60:0]  msg_ff, msg_in;
   logic [1:0]   part_ff, part_in;
   logic [511:0] blk_ff, blk_in;

   logic [63:0]  sh_data;
   logic [3:0]   sh_k;
   logic [6:0]   sh_bits;
   logic [6:0]   fill_sum;
   logic [6:0]   room, gap;
   logic [3:0]   req_cnt;
   logic [255:0] chain;

   sha256md_pkg::rnd_ctl_type rnd_ctl;
   sha256md_pkg::rnd_sts_type rnd_sts;

   sha256md_round u_round (
      .clock (clock),
      .reset (reset),
      .ctl   (rnd_ctl),
      .block (blk_ff),
      .sts   (rnd_sts),
      .chain (chain)
   );

   assign req_cnt  = (req_data.byte_count > 4'd8) ? 4'd8 : req_data.byte_count;
   assign room     = 7'd64 - {1'b0, fill_ff};
   assign gap      = ((fill_ff <= 6'd56) ? 7'd56 : 7'd64) - {1'b0, fill_ff};
   assign sh_bits  = {sh_k, 3'b000};
   assign fill_sum = {1'b0, fill_ff} + {3'b000, sh_k};
   // bytes enter at the bottom, so after 64 of them byte 0 sits at the top
   assign blk_in   = (blk_ff << sh_bits) | ({448'd0, sh_data} >> (7'd64 - sh_bits));
   assign fill_in  = fill_sum[5:0];

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);

   always_comb begin
      state_in         = state_ff;
      ret_in           = ret_ff;
      pend_in          = pend_ff;
      pend_cnt_in      = pend_cnt_ff;
      last_in          = last_ff;
      msg_in           = msg_ff;
      part_in          = part_ff;
      sh_data          = 64'd0;
      sh_k             = 4'd0;
      rnd_ctl.start      = 1'b0;
      rnd_ctl.init_chain = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               pend_in     = req_data.message_word;
               pend_cnt_in = req_cnt;
               last_in     = req_data.is_last;
               msg_in      = msg_ff + {57'd0, req_cnt};
               state_in    = S_LOAD;
            end
         end
         S_LOAD: begin
            sh_data     = pend_ff;
            sh_k        = ({3'b000, pend_cnt_ff} <= room) ? pend_cnt_ff : room[3:0];
            pend_in     = pend_ff << sh_bits;
            pend_cnt_in = pend_cnt_ff - sh_k;
            if (fill_sum[6]) begin
               ret_in   = S_LOAD;
               state_in = S_KICK;
            end else if (last_ff) begin
               state_in = S_MARK;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_MARK: begin
            sh_data = PAD_WORD;
            sh_k    = 4'd1;
            if (fill_sum[6]) begin
               ret_in   = S_ZERO;
               state_in = S_KICK;
            end else begin
               state_in = S_ZERO;
            end
         end
         S_ZERO: begin
            // zero fill up to the length field, finishing the block first if past it
            if (fill_ff == 6'd56) begin
               state_in = S_LEN;
            end else begin
               sh_k = (gap > 7'd8) ? 4'd8 : gap[3:0];
               if (fill_sum[6]) begin
                  ret_in   = S_ZERO;
                  state_in = S_KICK;
               end
            end
         end
         S_LEN: begin
            sh_data  = {msg_ff, 3'b000};
            sh_k     = 4'd8;
            ret_in   = S_OUT;
            state_in = S_KICK;
         end
         S_KICK: begin
            rnd_ctl.start = 1'b1;
            state_in      = S_WAIT;
         end
         S_WAIT: begin
            if (rnd_sts.done) begin
               state_in = ret_ff;
            end
         end
         S_OUT: begin
            if (rsp_ready) begin
               part_in = part_ff + 2'd1;
               if (part_ff == 2'd3) begin
                  rnd_ctl.init_chain = 1'b1;
                  msg_in             = 61'd0;
                  last_in            = 1'b0;
                  state_in           = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         ret_ff      <= S_IDLE;
         pend_cnt_ff <= 4'd0;
         last_ff     <= 1'b0;
         fill_ff     <= 6'd0;
         msg_ff      <= 61'd0;
         part_ff     <= 2'd0;
      end else begin
         state_ff    <= state_in;
         ret_ff      <= ret_in;
         pend_cnt_ff <= pend_cnt_in;
         last_ff     <= last_in;
         fill_ff     <= fill_in;
         msg_ff      <= msg_in;
         part_ff     <= part_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      blk_ff  <= blk_in;
   end

   always_comb begin
      case (part_ff)
         2'd0:    rsp_data.digest_part = chain[255:192];
         2'd1:    rsp_data.digest_part = chain[191:128];
         2'd2:    rsp_data.digest_part = chain[127:64];
         default: rsp_data.digest_part = chain[63:0];
      endcase
   end

   assign rsp_data.part_index = part_ff;
   assign rsp_data.last_part  = (part_ff == 2'd3);

endmodule

[rtl/sha256md_check.sv]
// port-level checks for the sha-256 digest block, bound to the top level
// depends on sha256md_pkg and assert_macros.svh
`include "assert_macros.svh"

module sha256md_check (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input sha256md_pkg::req_data_type req_data,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input sha256md_pkg::rsp_data_type rsp_data
);

   // a stalled digest part holds
   `SMD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

   // input is never taken while digest parts are pending
   `SMD_ASSERT_NOW(a_no_overlap, clock, reset, rsp_valid, !req_ready)

   // last flag goes with the fourth part only
   `SMD_ASSERT_NOW(a_last_part, clock, reset, rsp_valid, rsp_data.last_part == (rsp_data.part_index == 2'd3))

   // parts come out in order without gaps
   `SMD_ASSERT_NEXT(a_part_order, clock, reset, rsp_valid && rsp_ready && !rsp_data.last_part, rsp_valid && (rsp_data.part_index == $past(rsp_data.part_index) + 2'd1))

   // the block is not ready again in the cycle after it accepts an item
   `SMD_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)

endmodule

bind sha256_message_digest sha256md_check u_sha256md_check (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
